[src/ndlr_pkg.sv]
`timescale 1ns / 1ps

package ndlr_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS     = 16;
  localparam int GAIN_W          = 15;
  localparam int FRAC_BITS       = 15;
  localparam int PERIOD_W        = 11;
  localparam int VOICES          = 3;
  localparam int VOICE_W         = 2;
  localparam int MIX_W           = SAMPLE_BITS + 1;
  localparam int IN_TDATA_W      = 48;
  localparam int OUT_TDATA_W     = 40;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 15;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ROOT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FIFTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_OCTAVE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_GAIN   = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_ROOT_RST   = 11'd674;
  localparam logic [PERIOD_W-1:0] PERIOD_FIFTH_RST  = 11'd450;
  localparam logic [PERIOD_W-1:0] PERIOD_OCTAVE_RST = 11'd337;
  localparam logic [GAIN_W-1:0]   LEAK_GAIN_RST     = 15'd3277;
  localparam logic [GAIN_W-1:0]   SMOOTH_GAIN_RST   = 15'd3277;

  localparam logic [VOICE_W-1:0] VOICE_ROOT   = 2'd0;
  localparam logic [VOICE_W-1:0] VOICE_FIFTH  = 2'd1;
  localparam logic [VOICE_W-1:0] VOICE_OCTAVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_LEAK,
    ST_SMOOTH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic rd_en;
    logic wr_en;
    logic out_load;
  } ctrl_t;

endpackage

[src/ndlr_mem.sv]
`timescale 1ns / 1ps

module ndlr_mem #(
  parameter int DEPTH = ndlr_pkg::TABLE_DEPTH_DEF,
  parameter int WIDTH = ndlr_pkg::SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/ndlr_approach.sv]
`timescale 1ns / 1ps

// r = sat(a + floor((b - a) * g / 2^FRAC))
module ndlr_approach (
  input  logic signed [ndlr_pkg::SAMPLE_BITS-1:0] a,
  input  logic signed [ndlr_pkg::SAMPLE_BITS-1:0] b,
  input  logic        [ndlr_pkg::GAIN_W-1:0]      g,
  output logic signed [ndlr_pkg::SAMPLE_BITS-1:0] r
);

  localparam int SW  = ndlr_pkg::SAMPLE_BITS;
  localparam int GW  = ndlr_pkg::GAIN_W;
  localparam int PRW = SW + GW + 2;

  localparam logic signed [PRW-1:0] SMAX = {{(PRW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PRW-1:0] SMIN = {{(PRW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  logic signed [SW:0]    diff;
  logic signed [PRW-1:0] prod;
  logic signed [PRW-1:0] sum;

  always_comb begin
    diff = $signed({b[SW-1], b}) - $signed({a[SW-1], a});
    prod = diff * $signed({1'b0, g});
    sum  = $signed({{(PRW-SW){a[SW-1]}}, a}) + (prod >>> ndlr_pkg::FRAC_BITS);
    if (sum > SMAX) begin
      r = SMAX[SW-1:0];
    end else if (sum < SMIN) begin
      r = SMIN[SW-1:0];
    end else begin
      r = sum[SW-1:0];
    end
  end

endmodule

[src/noise_delay_line_resonator_stereo.sv]
`timescale 1ns / 1ps

// Three-voice noise-excited delay-line resonator with a stereo mix.
// in_*  : one transaction per sample tick, three Q1.15 noise samples.
// out_* : one transaction per tick, left = root + fifth, right = root + octave
//         lowpass outputs, Q2.15.
// cfg_* : register writes (periods, leak gain, smooth gain); issue them only
//         while the block is idle. cfg_ready is always high. A period write
//         clears that voice's table (via its fill count), lowpass and position.
// Timing: a tick is accepted in the idle state, then each voice passes
// through a table read, a leak update and write-back, and a lowpass update,
// the updates sharing the one multiply-and-saturate unit; then the output
// state loads the output register. A new tick is taken only after the block
// has returned to idle. The output register holds its transaction while
// out_tready is low, and the next tick is already accepted and computed;
// only the load of its result waits for the register to free up.
// Reset (rst_n low, synchronous) restores the register defaults and empties
// all tables at once; no clearing pass is needed.
module noise_delay_line_resonator_stereo #(
  parameter int TABLE_DEPTH = ndlr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // noise_root[15:0], noise_fifth[31:16], noise_octave[47:32]
  input  logic [ndlr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // left_mix[16:0], right_mix[33:17], zero[39:34]
  output logic [ndlr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ndlr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ndlr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW  = ndlr_pkg::SAMPLE_BITS;
  localparam int NV  = ndlr_pkg::VOICES;
  localparam int VW  = ndlr_pkg::VOICE_W;
  localparam int PRD = ndlr_pkg::PERIOD_W;
  localparam int PW  = $clog2(TABLE_DEPTH);
  localparam int FW  = PW + 1;
  localparam int CW  = (FW > PRD) ? FW : PRD;

  function automatic logic [FW-1:0] eff_period(input logic [PRD-1:0] p);
    logic [CW-1:0] pe;
    logic [CW-1:0] d;
    pe = CW'(p);
    d  = CW'(TABLE_DEPTH);
    if (pe == '0) begin
      return FW'(1);
    end else if (pe > d) begin
      return FW'(TABLE_DEPTH);
    end else begin
      return FW'(pe);
    end
  endfunction

  function automatic logic [PRD-1:0] period_rst(input int v);
    case (v)
      0:       return ndlr_pkg::PERIOD_ROOT_RST;
      1:       return ndlr_pkg::PERIOD_FIFTH_RST;
      default: return ndlr_pkg::PERIOD_OCTAVE_RST;
    endcase
  endfunction

  ndlr_pkg::state_t state_r, state_nxt;
  ndlr_pkg::ctrl_t  ctl;

  logic [PRD-1:0]               period_r [NV];
  logic [ndlr_pkg::GAIN_W-1:0]  leak_r, smooth_gain_r;
  logic [PW-1:0]                pos_r [NV];
  logic [FW-1:0]                fill_r [NV];
  logic signed [SW-1:0]         smooth_r [NV];
  logic signed [SW-1:0]         noise_r [NV];
  logic [VW-1:0]                v_r;
  logic [PW-1:0]                cur_pos_r;
  logic                         hit_r;
  logic signed [SW-1:0]         entry_r;
  logic                         out_valid_r;
  logic [ndlr_pkg::MIX_W-1:0]   left_r, right_r;

  logic [SW-1:0]                rd_data [NV];
  logic signed [SW-1:0]         rd_sel;
  logic [FW-1:0]                eff_cur;
  logic [FW-1:0]                pos_inc;
  logic [PW-1:0]                pos_n;
  logic signed [SW-1:0]         alu_a, alu_b, alu_r;
  logic [ndlr_pkg::GAIN_W-1:0]  alu_g;
  logic                         cfg_wr;

  // ---------------- table memories ----------------
  for (genvar gv = 0; gv < NV; gv++) begin : g_voice
    ndlr_mem #(
      .DEPTH(TABLE_DEPTH),
      .WIDTH(SW)
    ) u_mem (
      .clk    (clk),
      .wr_en  (ctl.wr_en && (v_r == VW'(gv))),
      .wr_addr(cur_pos_r),
      .wr_data(alu_r),
      .rd_en  (ctl.rd_en && (v_r == VW'(gv))),
      .rd_addr(pos_n),
      .rd_data(rd_data[gv])
    );
  end

  // ---------------- shared update unit ----------------
  ndlr_approach u_alu (
    .a(alu_a),
    .b(alu_b),
    .g(alu_g),
    .r(alu_r)
  );

  always_comb begin
    eff_cur = eff_period(period_r[v_r]);
    pos_inc = {1'b0, pos_r[v_r]} + FW'(1);
    pos_n   = (pos_inc >= eff_cur) ? '0 : pos_inc[PW-1:0];
    rd_sel  = hit_r ? $signed(rd_data[v_r]) : '0;
    if (state_r == ndlr_pkg::ST_SMOOTH) begin
      alu_a = smooth_r[v_r];
      alu_b = entry_r;
      alu_g = smooth_gain_r;
    end else begin
      alu_a = rd_sel;
      alu_b = noise_r[v_r];
      alu_g = leak_r;
    end
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ndlr_pkg::ST_IDLE:   if (in_tvalid) state_nxt = ndlr_pkg::ST_ADDR;
      ndlr_pkg::ST_ADDR:   state_nxt = ndlr_pkg::ST_LEAK;
      ndlr_pkg::ST_LEAK:   state_nxt = ndlr_pkg::ST_SMOOTH;
      ndlr_pkg::ST_SMOOTH: begin
        if (v_r == ndlr_pkg::VOICE_OCTAVE) state_nxt = ndlr_pkg::ST_OUT;
        else                               state_nxt = ndlr_pkg::ST_ADDR;
      end
      ndlr_pkg::ST_OUT:    if (!out_valid_r || out_tready) state_nxt = ndlr_pkg::ST_IDLE;
      default:             state_nxt = ndlr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      ndlr_pkg::ST_IDLE: ctl.in_ready = 1'b1;
      ndlr_pkg::ST_ADDR: ctl.rd_en    = 1'b1;
      ndlr_pkg::ST_LEAK: ctl.wr_en    = 1'b1;
      ndlr_pkg::ST_OUT:  ctl.out_load = !out_valid_r || out_tready;
      default:           ctl = '0;
    endcase
  end

  assign cfg_wr = cfg_valid;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ndlr_pkg::ST_IDLE;
      v_r           <= ndlr_pkg::VOICE_ROOT;
      out_valid_r   <= 1'b0;
      leak_r        <= ndlr_pkg::LEAK_GAIN_RST;
      smooth_gain_r <= ndlr_pkg::SMOOTH_GAIN_RST;
      for (int i = 0; i < NV; i++) begin
        period_r[i] <= period_rst(i);
        pos_r[i]    <= PW'(eff_period(period_rst(i)) - FW'(1));
        fill_r[i]   <= '0;
        smooth_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (ctl.in_ready && in_tvalid) begin
        v_r <= ndlr_pkg::VOICE_ROOT;
        for (int i = 0; i < NV; i++) begin
          noise_r[i] <= $signed(in_tdata[i*SW +: SW]);
        end
      end

      if (ctl.rd_en) begin
        pos_r[v_r] <= pos_n;
        cur_pos_r  <= pos_n;
        hit_r      <= ({1'b0, pos_n} < fill_r[v_r]);
      end

      if (ctl.wr_en) begin
        entry_r <= alu_r;
        if (!hit_r) begin
          fill_r[v_r] <= fill_r[v_r] + FW'(1);
        end
      end

      if (state_r == ndlr_pkg::ST_SMOOTH) begin
        smooth_r[v_r] <= alu_r;
        v_r           <= v_r + VW'(1);
      end

      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
        left_r  <= {smooth_r[0][SW-1], smooth_r[0]} + {smooth_r[1][SW-1], smooth_r[1]};
        right_r <= {smooth_r[0][SW-1], smooth_r[0]} + {smooth_r[2][SW-1], smooth_r[2]};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr) begin
        case (cfg_index)
          ndlr_pkg::REG_PERIOD_ROOT,
          ndlr_pkg::REG_PERIOD_FIFTH,
          ndlr_pkg::REG_PERIOD_OCTAVE: begin
            period_r[cfg_index[VW-1:0]] <= cfg_data[PRD-1:0];
            pos_r[cfg_index[VW-1:0]]    <= PW'(eff_period(cfg_data[PRD-1:0]) - FW'(1));
            fill_r[cfg_index[VW-1:0]]   <= '0;
            smooth_r[cfg_index[VW-1:0]] <= '0;
          end
          ndlr_pkg::REG_LEAK_GAIN:   leak_r        <= cfg_data;
          ndlr_pkg::REG_SMOOTH_GAIN: smooth_gain_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign in_tready  = ctl.in_ready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ndlr_pkg::OUT_TDATA_W - 2*ndlr_pkg::MIX_W){1'b0}}, right_r, left_r};

endmodule
